FILE: hw/rtl/lvd_pkg.sv
// Shared types, constants and saturation helpers for the Legendre value/derivative block.
package lvd_pkg;

	// Field widths
	localparam int unsigned POINT_W  = 32;
	localparam int unsigned DEGREE_W = 7;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned SLOPE_W  = 43;

	// Default for the degree limit
	localparam int unsigned MAX_DEGREE_DEF = 64;

	// Multiplier cell operand and result widths
	localparam int unsigned CELL_A_W  = 44;
	localparam int unsigned CELL_B_W  = 33;
	localparam int unsigned CELL_P_W  = 48;
	localparam int unsigned MAG_LO_W  = 16;
	localparam int unsigned DSUM_W    = CELL_P_W + 2;

	// Rounding shifts: Q30 products and reciprocal products
	localparam int unsigned SHIFT_P = 30;
	localparam int unsigned SHIFT_R = 32;

	// Width of the saturated-degree compare
	localparam int unsigned NCMP_W = 10;

	// Recurrence step sequencing
	localparam int unsigned PHASE_W    = 3;
	localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd5;

	// Fixed-point constants
	localparam logic signed [VALUE_W-1:0] ONE_Q30   = 32'sh4000_0000;
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'shC000_0000;
	localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = 43'sh3FF_FFFF_FFFF;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// Clamp a cell result to [-1.0, 1.0] in Q1.30
	function automatic logic signed [VALUE_W-1:0] sat_value(
		input logic signed [CELL_P_W-1:0] v);
		logic signed [VALUE_W-1:0] res;
		if (v > CELL_P_W'(ONE_Q30))
			res = ONE_Q30;
		else if (v < CELL_P_W'(VALUE_MIN))
			res = VALUE_MIN;
		else
			res = v[VALUE_W-1:0];
		return res;
	endfunction

	// Clamp a derivative sum to +/-(2^42-1)
	function automatic logic signed [SLOPE_W-1:0] sat_slope(
		input logic signed [DSUM_W-1:0] v);
		logic signed [SLOPE_W-1:0] res;
		if (v > DSUM_W'(SLOPE_MAX))
			res = SLOPE_MAX;
		else if (v < -DSUM_W'(SLOPE_MAX))
			res = -SLOPE_MAX;
		else
			res = v[SLOPE_W-1:0];
		return res;
	endfunction

endpackage

FILE: hw/rtl/lvd_in_if.sv
// Request channel: evaluation point and degree with valid/ready.
interface lvd_in_if import lvd_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [POINT_W-1:0]   point;
	logic        [DEGREE_W-1:0]  degree;

	modport source (output valid, output point, output degree, input ready);
	modport sink   (input valid, input point, input degree, output ready);
endinterface

FILE: hw/rtl/lvd_out_if.sv
// Result channel: polynomial value and derivative with valid/ready.
interface lvd_out_if import lvd_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  value;
	logic signed [SLOPE_W-1:0]  slope;

	modport source (output valid, output value, output slope, input ready);
	modport sink   (input valid, input value, input slope, output ready);
endinterface

FILE: hw/rtl/lvd_mul_cell.sv
// Two-stage signed multiply cell with round-half-away-from-zero right shift.
module lvd_mul_cell import lvd_pkg::*; (
	input  logic                        clk,
	input  logic signed [CELL_A_W-1:0]  a,
	input  logic signed [CELL_B_W-1:0]  b,
	input  logic                        shift32,
	output logic signed [CELL_P_W-1:0]  prod
);

	localparam int unsigned HI_W  = CELL_A_W - MAG_LO_W + CELL_B_W;
	localparam int unsigned LO_W  = MAG_LO_W + CELL_B_W;
	localparam int unsigned SUM_W = HI_W + MAG_LO_W + 1;

	logic [CELL_A_W-1:0] ma;
	logic [CELL_B_W-1:0] mb;
	logic [HI_W-1:0]     hi_p;
	logic [LO_W-1:0]     lo_p;

	logic [HI_W-1:0]     hi_s1;
	logic [LO_W-1:0]     lo_s1;
	logic                neg_s1;
	logic                sh_s1;

	logic [SUM_W-1:0]    rnd;
	logic [SUM_W-1:0]    sum;
	logic [CELL_P_W-1:0] mag;

	// Sign-magnitude split and partial products
	always_comb begin
		ma   = a[CELL_A_W-1] ? CELL_A_W'(-a) : CELL_A_W'(a);
		mb   = b[CELL_B_W-1] ? CELL_B_W'(-b) : CELL_B_W'(b);
		hi_p = ma[CELL_A_W-1:MAG_LO_W] * mb;
		lo_p = ma[MAG_LO_W-1:0] * mb;
	end

	always_ff @(posedge clk) begin
		hi_s1  <= hi_p;
		lo_s1  <= lo_p;
		neg_s1 <= a[CELL_A_W-1] ^ b[CELL_B_W-1];
		sh_s1  <= shift32;
	end

	// Recombine, round, shift, restore sign
	always_comb begin
		rnd = sh_s1 ? (SUM_W'(1) << (SHIFT_R - 1)) : (SUM_W'(1) << (SHIFT_P - 1));
		sum = SUM_W'({hi_s1, MAG_LO_W'(0)}) + SUM_W'(lo_s1) + rnd;
		mag = sh_s1 ? CELL_P_W'(sum >> SHIFT_R) : CELL_P_W'(sum >> SHIFT_P);
	end

	always_ff @(posedge clk) begin
		prod <= neg_s1 ? -$signed(mag) : $signed(mag);
	end

endmodule

FILE: hw/rtl/lvd_mix_cell.sv
// Combine cell: Bonnet numerator and saturated derivative update for step k.
module lvd_mix_cell import lvd_pkg::*; #(
	parameter int unsigned KW = 7
) (
	input  logic                        clk,
	input  logic        [KW-1:0]        k,
	input  logic signed [VALUE_W-1:0]   prev,
	input  logic signed [VALUE_W-1:0]   cur,
	input  logic signed [CELL_P_W-1:0]  t,
	input  logic signed [CELL_P_W-1:0]  dx,
	output logic signed [CELL_A_W-1:0]  num,
	output logic signed [SLOPE_W-1:0]   der_next
);

	localparam int unsigned NUM_W = CELL_B_W + KW + 2;

	logic signed [KW+1:0]        k2p1;
	logic signed [KW:0]          ks;
	logic signed [KW+1:0]        kp1;
	logic signed [CELL_B_W-1:0]  t_n;
	logic signed [NUM_W-1:0]     scaled_t;
	logic signed [NUM_W-1:0]     scaled_prev;
	logic signed [DSUM_W-1:0]    scaled_cur;
	logic signed [DSUM_W-1:0]    dsum;

	// (2k+1)*t - k*prev and (k+1)*cur + x*der
	always_comb begin
		k2p1        = $signed({1'b0, k, 1'b1});
		ks          = $signed({1'b0, k});
		kp1         = $signed({1'b0, (KW+1)'(k) + (KW+1)'(1)});
		t_n         = t[CELL_B_W-1:0];
		scaled_t    = k2p1 * t_n;
		scaled_prev = ks * prev;
		scaled_cur  = kp1 * cur;
		dsum        = scaled_cur + DSUM_W'(dx);
	end

	always_ff @(posedge clk) begin
		num      <= CELL_A_W'(scaled_t - scaled_prev);
		der_next <= sat_slope(dsum);
	end

endmodule

FILE: hw/rtl/legendre_value_and_derivative_top.sv
// Top level: Legendre P_n(x) and P_n'(x) by the three-term recurrence on a ring of cells.
//
//   port     dir   flow        payload
//   request  sink  valid/ready point (Q1.30), degree
//   result   src   valid/ready value (Q1.30), slope (Q12.30)
//
// One request at a time. Degree n is saturated to MAX_DEGREE; degrees 0 and 1 skip the
// recurrence. Each recurrence step is the loop x*P multiply cell -> combine cell ->
// reciprocal multiply cell -> state update.
// Reset clears the controller and the result valid; datapath registers are not reset.
// A stalled result is held in the output register; the next request is taken meanwhile.
module legendre_value_and_derivative_top import lvd_pkg::*; #(
	parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF
) (
	input logic       clk,
	input logic       arst_n,
	lvd_in_if.sink    request,
	lvd_out_if.source result
);

	localparam int unsigned KW    = $clog2(MAX_DEGREE + 1);
	localparam int unsigned ROM_D = MAX_DEGREE + 1;

	state_t                     state_q;
	logic [PHASE_W-1:0]         phase_q;
	logic [KW-1:0]              k_q;
	logic [KW-1:0]              n_q;
	logic                       out_valid_q;

	logic signed [POINT_W-1:0]  x_q;
	logic signed [VALUE_W-1:0]  cur_q;
	logic signed [VALUE_W-1:0]  prev_q;
	logic signed [SLOPE_W-1:0]  der_q;
	logic signed [VALUE_W-1:0]  value_q;
	logic signed [SLOPE_W-1:0]  slope_q;

	logic                       in_fire;
	logic                       step_done;
	logic                       out_load;
	logic [NCMP_W-1:0]          deg_w;
	logic [NCMP_W-1:0]          n_sat;
	logic [KW-1:0]              n_new;
	logic [KW-1:0]              k_next;

	logic signed [CELL_P_W-1:0] t_p;
	logic signed [CELL_P_W-1:0] dx_p;
	logic signed [CELL_P_W-1:0] next_p;
	logic signed [CELL_A_W-1:0] num_p;
	logic signed [SLOPE_W-1:0]  der_p;

	logic [SHIFT_R-1:0]         recip_rom [ROM_D];
	logic [SHIFT_R-1:0]         recip_k;

	// Reciprocal table: round(2^32 / d), unused below d = 2
	for (genvar g = 0; g < ROM_D; g++) begin : g_recip
		localparam logic [63:0] RV = (g < 2) ? 64'd0 :
			((64'd1 << SHIFT_R) + 64'(g / 2)) / 64'((g < 2) ? 1 : g);
		assign recip_rom[g] = RV[SHIFT_R-1:0];
	end

	// Handshakes, degree saturation, step control
	always_comb begin
		in_fire   = request.valid && request.ready;
		deg_w     = NCMP_W'(request.degree);
		n_sat     = (deg_w > NCMP_W'(MAX_DEGREE)) ? NCMP_W'(MAX_DEGREE) : deg_w;
		n_new     = n_sat[KW-1:0];
		k_next    = k_q + KW'(1);
		step_done = (state_q == ST_RUN) && (phase_q == PHASE_LAST);
		out_load  = (state_q == ST_DONE) && (!out_valid_q || result.ready);
		recip_k   = recip_rom[k_next];
	end

	assign request.ready = (state_q == ST_IDLE);
	assign result.valid  = out_valid_q;
	assign result.value  = value_q;
	assign result.slope  = slope_q;

	// Controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			k_q         <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register occupancy
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.valid && result.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						n_q     <= n_new;
						k_q     <= KW'(1);
						phase_q <= '0;
						state_q <= (n_new > KW'(1)) ? ST_RUN : ST_DONE;
					end
				end
				ST_RUN: begin
					if (step_done) begin
						phase_q <= '0;
						k_q     <= k_next;
						if (k_next == n_q)
							state_q <= ST_DONE;
					end else begin
						phase_q <= phase_q + PHASE_W'(1);
					end
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Recurrence state
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q    <= request.point;
			prev_q <= ONE_Q30;
			if (n_new == KW'(0)) begin
				cur_q <= ONE_Q30;
				der_q <= '0;
			end else begin
				cur_q <= sat_value(CELL_P_W'(request.point));
				der_q <= SLOPE_W'(ONE_Q30);
			end
		end else if (step_done) begin
			cur_q  <= sat_value(next_p);
			prev_q <= cur_q;
			der_q  <= der_p;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q <= cur_q;
			slope_q <= der_q;
		end
	end

	// x * P_k
	lvd_mul_cell u_cell_xp (
		.clk     (clk),
		.a       (CELL_A_W'(x_q)),
		.b       (CELL_B_W'(cur_q)),
		.shift32 (1'b0),
		.prod    (t_p)
	);

	// x * D_k
	lvd_mul_cell u_cell_xd (
		.clk     (clk),
		.a       (CELL_A_W'(der_q)),
		.b       (CELL_B_W'(x_q)),
		.shift32 (1'b0),
		.prod    (dx_p)
	);

	lvd_mix_cell #(
		.KW (KW)
	) u_cell_mix (
		.clk      (clk),
		.k        (k_q),
		.prev     (prev_q),
		.cur      (cur_q),
		.t        (t_p),
		.dx       (dx_p),
		.num      (num_p),
		.der_next (der_p)
	);

	// numerator / (k+1) through the reciprocal
	lvd_mul_cell u_cell_div (
		.clk     (clk),
		.a       (num_p),
		.b       ($signed({1'b0, recip_k})),
		.shift32 (1'b1),
		.prod    (next_p)
	);

endmodule

FILE: hw/rtl/lvd_checker.sv
// Port-level checks for the Legendre block, bound to the top level.
module lvd_checker import lvd_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [VALUE_W-1:0]  value,
	input logic signed [SLOPE_W-1:0]  slope
);

	// one request in flight: ready drops after acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// value stays within [-1.0, 1.0]
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (value <= ONE_Q30) && (value >= VALUE_MIN))
		else $error("value out of range");

	// slope stays within its saturation bounds
	a_slope_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (slope <= SLOPE_MAX) && (slope >= -SLOPE_MAX))
		else $error("slope out of range");

	// stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// stalled result payload holds
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(value) && $stable(slope))
		else $error("result changed while stalled");

endmodule

bind legendre_value_and_derivative_top lvd_checker u_lvd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (request.valid),
	.in_ready  (request.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.value     (result.value),
	.slope     (result.slope)
);
